// ===== rtl/ilsd_pkg.sv =====
// Package for the indexed list: request, status and state codes, cell control
// struct and shared widths. No dependencies; used by ilsd_cell and the top level.
`default_nettype none

package ilsd_pkg;

  // Default list depth and the widest index the control struct carries
  localparam int CAPACITY_DEF = 64;
  localparam int IDX_MAX_W    = 11;

  // Field widths of the stream payloads
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 7;
  localparam int FOUND_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 16;

  typedef logic [IDX_MAX_W-1:0] idx_t;
  typedef logic [VALUE_W-1:0]   value_t;

  typedef enum logic [1:0] {
    REQ_INSERT,
    REQ_DELETE,
    REQ_MODIFY,
    REQ_SEARCH
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_RANGE,
    STAT_FULL,
    STAT_MISSING
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_SCAN,
    FSM_DELIVER
  } fsm_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_MODIFY
  } cell_cmd_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_cmd_t cmd;
    logic      scan_en;
    idx_t      pos;
    idx_t      count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ilsd_cell.sv =====
// One cell of the list row: holds one entry, shifts with its neighbours on
// insert and delete, and passes the search token on. Depends on ilsd_pkg.
`default_nettype none

module ilsd_cell #(
  parameter int INDEX = 0
) (
  input  wire                  clk,
  input  wire                  rst,
  input  ilsd_pkg::cell_ctrl_t ctrl,
  input  ilsd_pkg::value_t     key,
  input  ilsd_pkg::value_t     new_value,
  input  ilsd_pkg::value_t     left_value,
  input  ilsd_pkg::value_t     right_value,
  input  wire                  tok_in,
  output ilsd_pkg::value_t     value,
  output logic                 tok,
  output logic                 match
);

  localparam ilsd_pkg::idx_t MY_IDX = ilsd_pkg::idx_t'(INDEX);

  // Entry storage: take the new value, the lower or the upper neighbour
  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      ilsd_pkg::CELL_INSERT: begin
        if (MY_IDX == ctrl.pos) begin
          value <= new_value;
        end else if (MY_IDX > ctrl.pos) begin
          value <= left_value;
        end
      end
      ilsd_pkg::CELL_DELETE: begin
        if (MY_IDX >= ctrl.pos) begin
          value <= right_value;
        end
      end
      ilsd_pkg::CELL_MODIFY: begin
        if (MY_IDX == ctrl.pos) begin
          value <= new_value;
        end
      end
      default: begin
      end
    endcase
  end

  // Search token moves one cell per cycle while a scan runs
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in & ctrl.scan_en;
    end
  end

  // Only live entries can match
  assign match = (MY_IDX < ctrl.count) && (value == key);

endmodule

`default_nettype wire

// ===== rtl/indexed_list_insert_delete_search_top.sv =====
// Top level of the indexed list: request/result streams, control sequencer
// and the row of ilsd_cell instances. Depends on ilsd_pkg and ilsd_cell.
//
//  channel  | dir | fields (tdata, low bit first)
//  ---------+-----+---------------------------------------------------------
//  s_*      | in  | req_type[1:0] position[8:2] item_value[40:9], pad to 48
//  m_*      | out | status[1:0] found_position[7:2] entry_count[14:8], pad to 16
//
// Insert, delete and modify go through capture, an execute state in which the
// whole row shifts or writes at once, then output. A search walks a token
// along the row one cell per cycle until it hits a match or the last live
// entry; a search of an empty list visits no cell and reports missing.
// A new request is taken once the previous one has reached the output
// register, even while that result still waits for m_tready.
// rst is synchronous; entry contents are not reset, only the count, state, tokens and m_tvalid.
`default_nettype none

module indexed_list_insert_delete_search_top #(
  parameter int CAPACITY = ilsd_pkg::CAPACITY_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // req_type[1:0], position[8:2], item_value[40:9]
  input  wire  [ilsd_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // status[1:0], found_position[7:2], entry_count[14:8]
  output logic [ilsd_pkg::M_TDATA_W-1:0]    m_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  ilsd_pkg::fsm_t             state;
  ilsd_pkg::fsm_t             state_next;
  ilsd_pkg::req_t             req_q;
  logic [ilsd_pkg::POS_W-1:0] pos_q;
  ilsd_pkg::value_t           val_q;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [IDX_W-1:0]           scan_idx;
  ilsd_pkg::status_t          pend_status;
  logic [ilsd_pkg::FOUND_W-1:0] pend_found;

  ilsd_pkg::status_t    exec_status;
  ilsd_pkg::cell_ctrl_t ctrl;
  logic                 scan_start;
  logic                 hit;
  logic                 last_scan;
  logic                 out_load;
  ilsd_pkg::idx_t       cnt_ext;
  ilsd_pkg::idx_t       pos_ext;
  ilsd_pkg::idx_t       scan_ext;

  ilsd_pkg::value_t     vals [CAPACITY];
  logic [CAPACITY-1:0]  tok_vec;
  logic [CAPACITY-1:0]  match_vec;

  assign cnt_ext   = ilsd_pkg::idx_t'(count);
  assign pos_ext   = ilsd_pkg::idx_t'(pos_q);
  assign scan_ext  = ilsd_pkg::idx_t'(scan_idx);
  assign last_scan = (scan_ext + ilsd_pkg::idx_t'(1)) >= cnt_ext;
  assign hit       = |(tok_vec & match_vec);
  assign out_load  = (state == ilsd_pkg::FSM_DELIVER) && (!m_tvalid || m_tready);
  assign s_tready  = (state == ilsd_pkg::FSM_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ilsd_pkg::FSM_IDLE: begin
        if (s_tvalid) begin
          state_next = ilsd_pkg::FSM_EXEC;
        end
      end
      ilsd_pkg::FSM_EXEC: begin
        if (scan_start) begin
          state_next = ilsd_pkg::FSM_SCAN;
        end else begin
          state_next = ilsd_pkg::FSM_DELIVER;
        end
      end
      ilsd_pkg::FSM_SCAN: begin
        if (hit || last_scan) begin
          state_next = ilsd_pkg::FSM_DELIVER;
        end
      end
      ilsd_pkg::FSM_DELIVER: begin
        if (out_load) begin
          state_next = ilsd_pkg::FSM_IDLE;
        end
      end
      default: state_next = ilsd_pkg::FSM_IDLE;
    endcase
  end

  // Request decode and row control
  always_comb begin
    exec_status  = ilsd_pkg::STAT_OK;
    count_next   = count;
    scan_start   = 1'b0;
    ctrl.cmd     = ilsd_pkg::CELL_HOLD;
    ctrl.pos     = pos_ext;
    ctrl.count   = cnt_ext;
    if (state == ilsd_pkg::FSM_EXEC) begin
      case (req_q)
        ilsd_pkg::REQ_INSERT: begin
          if (pos_ext > cnt_ext) begin
            exec_status = ilsd_pkg::STAT_RANGE;
          end else if (cnt_ext >= ilsd_pkg::idx_t'(CAPACITY)) begin
            exec_status = ilsd_pkg::STAT_FULL;
          end else begin
            ctrl.cmd   = ilsd_pkg::CELL_INSERT;
            count_next = count + CNT_W'(1);
          end
        end
        ilsd_pkg::REQ_DELETE: begin
          if (pos_ext >= cnt_ext) begin
            exec_status = ilsd_pkg::STAT_RANGE;
          end else begin
            ctrl.cmd   = ilsd_pkg::CELL_DELETE;
            count_next = count - CNT_W'(1);
          end
        end
        ilsd_pkg::REQ_MODIFY: begin
          if (pos_ext >= cnt_ext) begin
            exec_status = ilsd_pkg::STAT_RANGE;
          end else begin
            ctrl.cmd = ilsd_pkg::CELL_MODIFY;
          end
        end
        default: begin
          // search of an empty list fails at once
          if (count == '0) begin
            exec_status = ilsd_pkg::STAT_MISSING;
          end else begin
            scan_start = 1'b1;
          end
        end
      endcase
    end
    ctrl.scan_en = scan_start || (state == ilsd_pkg::FSM_SCAN);
  end

  // Sequencer and request registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilsd_pkg::FSM_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_q <= ilsd_pkg::req_t'(s_tdata[1:0]);
      pos_q <= s_tdata[8:2];
      val_q <= s_tdata[40:9];
    end
    case (state)
      ilsd_pkg::FSM_EXEC: begin
        pend_status <= exec_status;
        pend_found  <= '0;
        scan_idx    <= '0;
      end
      ilsd_pkg::FSM_SCAN: begin
        if (hit) begin
          pend_status <= ilsd_pkg::STAT_OK;
          pend_found  <= scan_ext[ilsd_pkg::FOUND_W-1:0];
        end else if (last_scan) begin
          pend_status <= ilsd_pkg::STAT_MISSING;
        end else begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: holds a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, cnt_ext[ilsd_pkg::COUNT_W-1:0], pend_found, pend_status};
    end
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ilsd_pkg::value_t left_value;
    ilsd_pkg::value_t right_value;
    logic             tok_in;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign tok_in     = scan_start;
    end else begin : g_mid
      assign left_value = vals[i-1];
      assign tok_in     = tok_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = vals[i+1];
    end

    ilsd_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key        (val_q),
      .new_value  (val_q),
      .left_value (left_value),
      .right_value(right_value),
      .tok_in     (tok_in),
      .value      (vals[i]),
      .tok        (tok_vec[i]),
      .match      (match_vec[i])
    );
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ilsd_pkg::idx_t'(count) <= ilsd_pkg::idx_t'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_token: assert property (@(posedge clk) disable iff (rst)
    (state == ilsd_pkg::FSM_SCAN) |-> $onehot(tok_vec))
    else $error("search token lost or duplicated");

  a_count_only_exec: assert property (@(posedge clk) disable iff (rst)
    (state != ilsd_pkg::FSM_EXEC) |=> $stable(count))
    else $error("count changed outside execution");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ilsd_pkg::FSM_EXEC))
    else $error("accepted request not executed");

endmodule

`default_nettype wire
